// ----- sv/pbe_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbe_pkg
// Shared constants and types for the power-by-exp/log series unit.
// ----------------------------------------------------------------------------
package pbe_pkg;

  localparam int FRAC_BITS = 24;
  localparam int MAX_TERMS = 64;
  localparam int K_W       = $clog2(MAX_TERMS + 1);

  localparam int BASE_W = 32;
  localparam int EXPO_W = 32;
  localparam int RES_W  = 40;
  localparam int TOL_W  = 16;

  typedef logic [63:0]        word_t;
  typedef logic signed [63:0] sword_t;

  localparam word_t ONE     = 64'd1 << FRAC_BITS;
  localparam word_t HALF    = ONE >> 1;
  localparam word_t THIRD   = ((ONE << 1) + 64'd3) / 64'd6;
  localparam word_t HI135   = (ONE * 64'd135 + 64'd50) / 64'd100;
  localparam word_t LO065   = (ONE * 64'd65 + 64'd50) / 64'd100;
  localparam word_t INT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  localparam logic [RES_W-1:0] OUT_MAX = '1;

  localparam int HI_LIM_MUL = 41 - FRAC_BITS;
  localparam int LO_LIM_MUL = FRAC_BITS + 1;

  localparam logic [TOL_W-1:0] TOL_RESET = 16'd2;

  // series selector
  localparam logic [1:0] SER_LN_HALF  = 2'd0;
  localparam logic [1:0] SER_LN_THIRD = 2'd1;
  localparam logic [1:0] SER_LN_Y     = 2'd2;
  localparam logic [1:0] SER_EXP      = 2'd3;

endpackage

// ----- sv/pbe_ifs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbe channel interfaces
// Valid/ready channels for requests, results and the tolerance register.
// ----------------------------------------------------------------------------
interface pbe_req_if;
  logic                                valid;
  logic                                ready;
  logic [pbe_pkg::BASE_W-1:0]          base_value;
  logic signed [pbe_pkg::EXPO_W-1:0]   exponent_value;
  modport source (output valid, output base_value, output exponent_value, input ready);
  modport sink   (input valid, input base_value, input exponent_value, output ready);
endinterface

interface pbe_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [pbe_pkg::RES_W-1:0]   power_result;
  logic                        saturated;
  logic                        bad_base;
  logic                        not_converged;
  modport source (output valid, output power_result, output saturated, output bad_base,
                  output not_converged, input ready);
  modport sink   (input valid, input power_result, input saturated, input bad_base,
                  input not_converged, output ready);
endinterface

interface pbe_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [pbe_pkg::TOL_W-1:0]   term_tolerance;
  modport source (output valid, output term_tolerance, input ready);
  modport sink   (input valid, input term_tolerance, output ready);
endinterface

// ----- sv/power_by_exp_log_series_unit.sv -----
`timescale 1ns / 1ps
// Operation: range reduction of the base by halving or doubling, then per series term a
//   multiply, round, divide and accumulate step, over ln(3/2), ln(4/3), ln(y) and exp,
//   plus glue states; a zero base goes straight to the output state.
// Throughput: one item at a time; the shared multiply/divide unit sets the rate.
// Reset: asynchronous active low; sequencer idle, no result pending, tolerance = 2.
// ----------------------------------------------------------------------------
// power_by_exp_log_series_unit
// base^exponent = exp(exponent * ln(base)) via fixed-point series on one shared
// 16x32 multiplier and a radix-256 term-index divider.
// ----------------------------------------------------------------------------
module power_by_exp_log_series_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  pbe_req_if.sink   req_i,
  pbe_rsp_if.source rsp_o,
  pbe_cfg_if.sink   cfg_i
);
  import pbe_pkg::*;

  // sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_NORM = 4'd1;  // halve/double base into range
  localparam logic [3:0] S_MUL  = 4'd2;  // 4 partial products
  localparam logic [3:0] S_RND  = 4'd3;  // round, shift, clip
  localparam logic [3:0] S_DIV  = 4'd4;  // divide by term index
  localparam logic [3:0] S_ACC  = 4'd5;  // add term, test stop
  localparam logic [3:0] S_LNX  = 4'd6;  // ln(base) = L(y-1) + n*ln2
  localparam logic [3:0] S_CMP  = 4'd7;  // range check of exp argument
  localparam logic [3:0] S_OUT  = 4'd8;  // hand to output register

  logic [3:0]        state_q, state_d;
  logic [TOL_W-1:0]  tol_q;
  logic [BASE_W-1:0] y_q, y_d;
  logic signed [6:0] n_q, n_d;
  logic signed [EXPO_W-1:0] expo_q, expo_d;
  logic [1:0]        ser_q, ser_d;
  logic [K_W-1:0]    k_q, k_d;
  sword_t            pw_q, pw_d, sum_q, sum_d, sarg_q, sarg_d, ln2_q, ln2_d;
  sword_t            lim_hi_q, lim_hi_d, lim_lo_q, lim_lo_d;
  word_t             mul_a_q, mul_a_d;
  logic [31:0]       mul_b_q, mul_b_d;
  logic              mul_neg_q, mul_neg_d;
  logic              argm_q, argm_d;
  logic [95:0]       acc_q, acc_d;
  logic [1:0]        cnt_q, cnt_d;
  word_t             dv_q, dv_d;
  logic [K_W:0]      rem_q, rem_d;
  logic [2:0]        dcnt_q, dcnt_d;
  logic [RES_W-1:0]  res_q, res_d;
  logic              sat_q, sat_d, bad_q, bad_d, unconv_q, unconv_d;
  logic              ov_q, ov_d;
  logic [RES_W-1:0]  o_res_q, o_res_d;
  logic              o_sat_q, o_sat_d, o_bad_q, o_bad_d, o_unc_q, o_unc_d;

  // multiplier datapath: one 16x32 product per cycle
  logic [15:0] a_chunk;
  logic [47:0] partial;
  logic [95:0] addend;
  assign a_chunk = mul_a_q[{cnt_q, 4'b0000} +: 16];
  assign partial = a_chunk * mul_b_q;
  assign addend  = {48'b0, partial} << {cnt_q, 4'b0000};

  // rounding half away from zero on the magnitude, clip to 2^63-1
  logic [95:0] rnd_sum, rnd_shift;
  word_t       rnd_mag;
  sword_t      rnd_val;
  assign rnd_sum   = acc_q + (96'd1 << (FRAC_BITS - 1));
  assign rnd_shift = rnd_sum >> FRAC_BITS;
  assign rnd_mag   = (|rnd_shift[95:63]) ? INT_MAX : rnd_shift[63:0];
  assign rnd_val   = mul_neg_q ? -sword_t'(rnd_mag) : sword_t'(rnd_mag);

  // divider: eight restoring steps per cycle
  word_t        div_dv;
  logic [K_W:0] div_rem;
  always_comb begin
    div_dv  = dv_q;
    div_rem = rem_q;
    for (int s = 0; s < 8; s++) begin
      div_rem = {div_rem[K_W-1:0], div_dv[63]};
      div_dv  = {div_dv[62:0], 1'b0};
      if (div_rem >= {1'b0, k_q}) begin
        div_rem   = div_rem - {1'b0, k_q};
        div_dv[0] = 1'b1;
      end
    end
  end

  sword_t term_val;
  logic   term_small, last_term;
  assign term_val   = mul_neg_q ? -sword_t'(dv_q) : sword_t'(dv_q);
  assign term_small = dv_q <= word_t'(tol_q);
  assign last_term  = k_q == K_W'(MAX_TERMS);

  // ln(base) assembly
  logic signed [39:0] n_ln2;
  sword_t             lnx;
  word_t              lnx_mag;
  assign n_ln2   = n_q * $signed({1'b0, ln2_q[31:0]});
  assign lnx     = sum_q + sword_t'(n_ln2);
  assign lnx_mag = lnx[63] ? word_t'(-lnx) : word_t'(lnx);

  assign req_i.ready = state_q == S_IDLE;
  assign cfg_i.ready = 1'b1;
  assign rsp_o.valid = ov_q;
  assign rsp_o.power_result  = o_res_q;
  assign rsp_o.saturated     = o_sat_q;
  assign rsp_o.bad_base      = o_bad_q;
  assign rsp_o.not_converged = o_unc_q;

  logic       start_ser;
  logic [1:0] start_id;
  sword_t     start_arg, new_sum;
  word_t      next_mag;

  always_comb begin
    state_d = state_q;   y_d = y_q;         n_d = n_q;       expo_d = expo_q;
    ser_d = ser_q;       k_d = k_q;         pw_d = pw_q;     sum_d = sum_q;
    sarg_d = sarg_q;     ln2_d = ln2_q;     lim_hi_d = lim_hi_q; lim_lo_d = lim_lo_q;
    mul_a_d = mul_a_q;   mul_b_d = mul_b_q; mul_neg_d = mul_neg_q; argm_d = argm_q;
    acc_d = acc_q;       cnt_d = cnt_q;     dv_d = dv_q;     rem_d = rem_q;
    dcnt_d = dcnt_q;     res_d = res_q;     sat_d = sat_q;   bad_d = bad_q;
    unconv_d = unconv_q;
    ov_d = ov_q & ~rsp_o.ready;
    o_res_d = o_res_q;   o_sat_d = o_sat_q; o_bad_d = o_bad_q; o_unc_d = o_unc_q;
    start_ser = 1'b0;    start_id = SER_LN_HALF; start_arg = '0;
    new_sum = sum_q;     next_mag = '0;

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          expo_d   = req_i.exponent_value;
          y_d      = req_i.base_value;
          n_d      = '0;
          res_d    = '0;
          sat_d    = 1'b0;
          unconv_d = 1'b0;
          bad_d    = req_i.base_value == '0;
          state_d  = (req_i.base_value == '0) ? S_OUT : S_NORM;
        end
      end
      S_NORM: begin
        if (word_t'(y_q) > HI135) begin
          y_d = y_q >> 1;
          n_d = n_q + 7'sd1;
        end else if (word_t'(y_q) < LO065) begin
          y_d = y_q << 1;
          n_d = n_q - 7'sd1;
        end else begin
          start_ser = 1'b1;
          start_id  = SER_LN_HALF;
          start_arg = sword_t'(HALF);
        end
      end
      S_MUL: begin
        acc_d = acc_q + addend;
        cnt_d = cnt_q + 2'd1;
        if (cnt_q == 2'd3) state_d = S_RND;
      end
      S_RND: begin
        if (argm_q) begin
          sarg_d  = rnd_val;
          state_d = S_CMP;
        end else begin
          if (ser_q != SER_EXP) pw_d = rnd_val;
          dv_d    = rnd_mag + word_t'(k_q >> 1);
          rem_d   = '0;
          dcnt_d  = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        dv_d   = div_dv;
        rem_d  = div_rem;
        dcnt_d = dcnt_q + 3'd1;
        if (dcnt_q == 3'd7) state_d = S_ACC;
      end
      S_ACC: begin
        if (ser_q == SER_EXP) begin
          new_sum  = sum_q + term_val;
          pw_d     = term_val;
          next_mag = dv_q;
        end else begin
          new_sum  = k_q[0] ? sum_q + term_val : sum_q - term_val;
          next_mag = pw_q[63] ? word_t'(-pw_q) : word_t'(pw_q);
        end
        sum_d = new_sum;
        if (!term_small && last_term) unconv_d = 1'b1;
        if (!term_small && !last_term) begin
          k_d       = k_q + K_W'(1);
          mul_a_d   = next_mag;
          mul_neg_d = (ser_q == SER_EXP ? term_val[63] : pw_q[63]) ^ sarg_q[63];
          acc_d     = '0;
          cnt_d     = '0;
          state_d   = S_MUL;
        end else begin
          case (ser_q)
            SER_LN_HALF: begin
              ln2_d     = new_sum;
              start_ser = 1'b1;
              start_id  = SER_LN_THIRD;
              start_arg = sword_t'(THIRD);
            end
            SER_LN_THIRD: begin
              ln2_d     = ln2_q + new_sum;
              start_ser = 1'b1;
              start_id  = SER_LN_Y;
              start_arg = sword_t'({32'b0, y_q}) - sword_t'(ONE);
            end
            SER_LN_Y: begin
              state_d = S_LNX;
            end
            default: begin
              // exponential done: clamp into the unsigned output range
              if (new_sum[63]) begin
                res_d = '0;
              end else if (word_t'(new_sum) > word_t'(OUT_MAX)) begin
                res_d = OUT_MAX;
                sat_d = 1'b1;
              end else begin
                res_d = new_sum[RES_W-1:0];
              end
              state_d = S_OUT;
            end
          endcase
        end
      end
      S_LNX: begin
        lim_hi_d  = ln2_q * sword_t'(HI_LIM_MUL);
        lim_lo_d  = -(ln2_q * sword_t'(LO_LIM_MUL));
        mul_a_d   = lnx_mag;
        mul_b_d   = expo_q[EXPO_W-1] ? 32'(-expo_q) : 32'(expo_q);
        mul_neg_d = lnx[63] ^ expo_q[EXPO_W-1];
        argm_d    = 1'b1;
        acc_d     = '0;
        cnt_d     = '0;
        state_d   = S_MUL;
      end
      S_CMP: begin
        argm_d = 1'b0;
        if (sarg_q > lim_hi_q) begin
          res_d   = OUT_MAX;
          sat_d   = 1'b1;
          state_d = S_OUT;
        end else if (sarg_q < lim_lo_q) begin
          res_d   = '0;
          state_d = S_OUT;
        end else begin
          start_ser = 1'b1;
          start_id  = SER_EXP;
          start_arg = sarg_q;
        end
      end
      S_OUT: begin
        if (!ov_q || rsp_o.ready) begin
          ov_d    = 1'b1;
          o_res_d = res_q;
          o_sat_d = sat_q;
          o_bad_d = bad_q;
          o_unc_d = unconv_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // launch a series: first term multiply uses pw = 1.0
    if (start_ser) begin
      ser_d     = start_id;
      sarg_d    = start_arg;
      pw_d      = sword_t'(ONE);
      sum_d     = (start_id == SER_EXP) ? sword_t'(ONE) : '0;
      k_d       = K_W'(1);
      mul_a_d   = ONE;
      mul_b_d   = start_arg[63] ? 32'(-start_arg) : 32'(start_arg);
      mul_neg_d = start_arg[63];
      argm_d    = 1'b0;
      acc_d     = '0;
      cnt_d     = '0;
      state_d   = S_MUL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      tol_q   <= TOL_RESET;
      ov_q    <= 1'b0;
      argm_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      argm_q  <= argm_d;
      if (cfg_i.valid) tol_q <= cfg_i.term_tolerance;
    end
  end

  always_ff @(posedge clk_i) begin
    y_q <= y_d;           n_q <= n_d;           expo_q <= expo_d;
    ser_q <= ser_d;       k_q <= k_d;           pw_q <= pw_d;
    sum_q <= sum_d;       sarg_q <= sarg_d;     ln2_q <= ln2_d;
    lim_hi_q <= lim_hi_d; lim_lo_q <= lim_lo_d;
    mul_a_q <= mul_a_d;   mul_b_q <= mul_b_d;   mul_neg_q <= mul_neg_d;
    acc_q <= acc_d;       cnt_q <= cnt_d;       dv_q <= dv_d;
    rem_q <= rem_d;       dcnt_q <= dcnt_d;     res_q <= res_d;
    sat_q <= sat_d;       bad_q <= bad_d;       unconv_q <= unconv_d;
    o_res_q <= o_res_d;   o_sat_q <= o_sat_d;   o_bad_q <= o_bad_d;
    o_unc_q <= o_unc_d;
  end

endmodule
